// ===== hw/rtl/cds_pkg.sv =====
package cds_pkg;

   // defaults for the top-level parameters
   localparam int BASE_YEAR_DEF = 1900;
   localparam int LAST_YEAR_DEF = 4095;
   localparam int MAX_STEP_DEF  = 65535;

   // internal widths, wide enough for every legal parameter setting
   localparam int YEAR_W     = 14;
   localparam int NUM_W      = 22;
   localparam int YMOD_W     = 9;
   localparam int STEP_W     = 16;
   localparam int STEP_LIM_W = 20;

   // port widths
   localparam int OUT_YEAR_W = 12;
   localparam int OUT_NUM_W  = 20;

   localparam int MONTHS      = 12;
   localparam int YEAR_CYCLE  = 400;
   localparam int COMMON_DAYS = 365;

   typedef enum logic [1:0] {
      OP_FWD  = 2'd0,
      OP_BACK = 2'd1,
      OP_LOAD = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   // job handed from the front end to the walker
   typedef struct packed {
      logic              load;
      logic              error;
      logic [NUM_W-1:0]  tgt;
      logic [3:0]        month;
      logic [4:0]        day;
      logic [YEAR_W-1:0] year;
   } job_type;

   // walker result
   typedef struct packed {
      logic              valid;
      logic              commit;
      logic              error;
      logic [3:0]        month;
      logic [4:0]        day;
      logic [YEAR_W-1:0] year;
      logic [NUM_W-1:0]  num;
      logic [2:0]        wd;
   } res_type;

   // calendar rules for the cursor year and the month in hand
   typedef struct packed {
      logic              leap_cur;
      logic              leap_prev;
      logic [4:0]        mlen;
      logic [YMOD_W-1:0] ymod_prev;
      logic [YMOD_W-1:0] ymod_next;
   } cal_type;

   // leap test on the year taken modulo 400
   function automatic logic is_leap(input logic [YMOD_W-1:0] r);
      return (r == '0) ||
             ((r[1:0] == 2'd0) && (r != YMOD_W'(100)) && (r != YMOD_W'(200)) &&
              (r != YMOD_W'(300)));
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m)
         4'd2: begin
            len = 5'd28 + {4'd0, leap};
         end
         4'd4, 4'd6, 4'd9, 4'd11: begin
            len = 5'd30;
         end
         default: begin
            len = 5'd31;
         end
      endcase
      return len;
   endfunction

   // modulo 7 of a small value (below 56)
   function automatic logic [2:0] mod7(input logic [5:0] v);
      logic [5:0] t;
      t = v;
      if (t >= 6'd28) t = t - 6'd28;
      if (t >= 6'd14) t = t - 6'd14;
      if (t >= 6'd7)  t = t - 6'd7;
      return t[2:0];
   endfunction

endpackage

// ===== hw/rtl/cds_cal.sv =====
module cds_cal (
   input  logic [cds_pkg::YMOD_W-1:0] ymod,
   input  logic [3:0]                 month,
   output cds_pkg::cal_type           cal
);

   localparam logic [cds_pkg::YMOD_W-1:0] YMOD_TOP =
      cds_pkg::YMOD_W'(cds_pkg::YEAR_CYCLE - 1);

   always_comb begin
      cal.ymod_prev = (ymod == '0) ? YMOD_TOP : ymod - cds_pkg::YMOD_W'(1);
      cal.ymod_next = (ymod == YMOD_TOP) ? '0 : ymod + cds_pkg::YMOD_W'(1);
      cal.leap_cur  = cds_pkg::is_leap(ymod);
      cal.leap_prev = cds_pkg::is_leap(cal.ymod_prev);
      cal.mlen      = cds_pkg::month_len(month, cal.leap_cur);
   end

endmodule

// ===== hw/rtl/cds_walker.sv =====
module cds_walker #(
   parameter int BASE_YEAR = cds_pkg::BASE_YEAR_DEF,
   parameter int LAST_YEAR = cds_pkg::LAST_YEAR_DEF,
   parameter int START_WD  = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_start,
   input  cds_pkg::job_type job,
   output cds_pkg::res_type res
);

   localparam int NUM_W  = cds_pkg::NUM_W;
   localparam int YEAR_W = cds_pkg::YEAR_W;
   localparam int YMOD_W = cds_pkg::YMOD_W;

   localparam logic [YEAR_W-1:0] BASE_Y   = YEAR_W'(BASE_YEAR);
   localparam logic [YEAR_W-1:0] LAST_Y   = YEAR_W'(LAST_YEAR);
   localparam logic [YMOD_W-1:0] BASE_MOD = YMOD_W'(BASE_YEAR % cds_pkg::YEAR_CYCLE);
   localparam logic [3:0]        LAST_MON = 4'(cds_pkg::MONTHS);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_YEAR   = 4'b0010,
      ST_MONTH  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type             state_ff, state_in;
   logic [YEAR_W-1:0]     yr_ff, yr_in;
   logic [YMOD_W-1:0]     ymod_ff, ymod_in;
   logic [NUM_W-1:0]      jan1_ff, jan1_in;
   logic [2:0]            jw_ff, jw_in;
   cds_pkg::job_type      job_ff, job_in;
   logic [3:0]            mon_ff, mon_in;
   logic [NUM_W-1:0]      ms_ff, ms_in;
   logic [2:0]            mw_ff, mw_in;
   cds_pkg::res_type      res_ff, res_in;

   cds_pkg::cal_type      cal;
   logic                  back_year, fwd_year, fwd_month, day_ok, sub;
   logic [NUM_W-1:0]      op_a, op_b, sum;
   logic [8:0]            ylen_cur, ylen_prev;
   logic [4:0]            day_less, off;
   logic [2:0]            jw_fwd, jw_back, mw_next, wd_fin;

   cds_cal u_cal (
      .ymod  (ymod_ff),
      .month (mon_ff),
      .cal   (cal)
   );

   assign ylen_cur  = 9'(cds_pkg::COMMON_DAYS) + {8'd0, cal.leap_cur};
   assign ylen_prev = 9'(cds_pkg::COMMON_DAYS) + {8'd0, cal.leap_prev};
   assign day_less  = job_ff.day - 5'd1;
   assign back_year = job_ff.load ? (yr_ff > job_ff.year) : (job_ff.tgt < jan1_ff);

   // shared adder
   always_comb begin
      op_a = '0;
      op_b = '0;
      sub  = 1'b0;
      case (state_ff)
         ST_YEAR: begin
            op_a = jan1_ff;
            op_b = back_year ? NUM_W'(ylen_prev) : NUM_W'(ylen_cur);
            sub  = back_year;
         end
         ST_MONTH: begin
            op_a = ms_ff;
            op_b = NUM_W'(cal.mlen);
         end
         ST_FINISH: begin
            if (job_ff.load) begin
               op_a = ms_ff;
               op_b = NUM_W'(day_less);
            end else begin
               op_a = job_ff.tgt;
               op_b = ms_ff;
               sub  = 1'b1;
            end
         end
         default: begin
            op_a = '0;
         end
      endcase
      sum = op_a + (sub ? ~op_b : op_b) + NUM_W'(sub);
   end

   assign fwd_year  = job_ff.load ? (yr_ff < job_ff.year)
                                  : ((yr_ff < LAST_Y) && (job_ff.tgt >= sum));
   assign fwd_month = job_ff.load ? (mon_ff < job_ff.month)
                                  : ((mon_ff < LAST_MON) && (job_ff.tgt >= sum));
   assign day_ok    = job_ff.day <= cal.mlen;

   assign jw_fwd  = cds_pkg::mod7(6'(jw_ff) + 6'd1 + 6'(cal.leap_cur));
   assign jw_back = cds_pkg::mod7(6'(jw_ff) + 6'd6 - 6'(cal.leap_prev));
   assign mw_next = cds_pkg::mod7(6'(mw_ff) + 6'(cal.mlen - 5'd28));
   assign off     = job_ff.load ? day_less : sum[4:0];
   assign wd_fin  = cds_pkg::mod7(6'(mw_ff) + 6'(off));

   always_comb begin
      state_in     = state_ff;
      yr_in        = yr_ff;
      ymod_in      = ymod_ff;
      jan1_in      = jan1_ff;
      jw_in        = jw_ff;
      job_in       = job_ff;
      mon_in       = mon_ff;
      ms_in        = ms_ff;
      mw_in        = mw_ff;
      res_in       = res_ff;
      res_in.valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (job_start) begin
               job_in   = job;
               state_in = ST_YEAR;
            end
         end
         ST_YEAR: begin
            if (back_year) begin
               yr_in   = yr_ff - YEAR_W'(1);
               ymod_in = cal.ymod_prev;
               jan1_in = sum;
               jw_in   = jw_back;
            end else if (fwd_year) begin
               yr_in   = yr_ff + YEAR_W'(1);
               ymod_in = cal.ymod_next;
               jan1_in = sum;
               jw_in   = jw_fwd;
            end else begin
               mon_in   = 4'd1;
               ms_in    = jan1_ff;
               mw_in    = jw_ff;
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (fwd_month) begin
               mon_in = mon_ff + 4'd1;
               ms_in  = sum;
               mw_in  = mw_next;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            res_in.valid = 1'b1;
            res_in.month = mon_ff;
            res_in.year  = yr_ff;
            res_in.wd    = wd_fin;
            if (job_ff.load) begin
               res_in.commit = day_ok;
               res_in.error  = !day_ok;
               res_in.day    = job_ff.day;
               res_in.num    = sum;
            end else begin
               res_in.commit = 1'b1;
               res_in.error  = job_ff.error;
               res_in.day    = sum[4:0] + 5'd1;
               res_in.num    = job_ff.tgt;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         yr_ff    <= BASE_Y;
         ymod_ff  <= BASE_MOD;
         jan1_ff  <= '0;
         jw_ff    <= 3'(START_WD);
         res_ff   <= '0;
      end else begin
         state_ff <= state_in;
         yr_ff    <= yr_in;
         ymod_ff  <= ymod_in;
         jan1_ff  <= jan1_in;
         jw_ff    <= jw_in;
         res_ff   <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      mon_ff <= mon_in;
      ms_ff  <= ms_in;
      mw_ff  <= mw_in;
   end

   assign res = res_ff;

endmodule

// ===== hw/rtl/calendar_date_stepper_core.sv =====
// Gregorian date counter. Holds month, day, year, a day number counted from 1 January
// BASE_YEAR and a weekday (0 Sunday), and takes one command word at a time: step
// forward, step back, or load a date. A command is taken when start is high and busy
// low; each command gives exactly one result word, shown for a single cycle with
// rsp_valid, and the receiver cannot hold it off, so capture it on that cycle. Steps
// and valid loads raise busy and run through a year/month walker that shares one
// adder: one year per cycle from the year of the last walked date to the target year,
// then one month per cycle. A load with a month, day or year out of range, and the
// unused operation code, are refused without busy, the error word appearing the
// cycle after the command; a load of a day beyond its month's length is refused at
// the end of the walk. A step beyond the first or last allowed day stops on that day
// with rsp_error_flag set; counts above MAX_STEP are saturated. Nothing changes on a
// refused load.
module calendar_date_stepper_core #(
   parameter int BASE_YEAR = cds_pkg::BASE_YEAR_DEF,
   parameter int LAST_YEAR = cds_pkg::LAST_YEAR_DEF,
   parameter int MAX_STEP  = cds_pkg::MAX_STEP_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [1:0]                     req_operation,
   input  logic [cds_pkg::STEP_W-1:0]     req_step_count,
   input  logic [3:0]                     req_new_month,
   input  logic [4:0]                     req_new_day,
   input  logic [cds_pkg::OUT_YEAR_W-1:0] req_new_year,
   output logic                           rsp_valid,
   output logic [3:0]                     rsp_month_out,
   output logic [4:0]                     rsp_day_out,
   output logic [cds_pkg::OUT_YEAR_W-1:0] rsp_year_out,
   output logic [cds_pkg::OUT_NUM_W-1:0]  rsp_day_number,
   output logic [2:0]                     rsp_weekday,
   output logic                           rsp_error_flag
);

   localparam int NUM_W  = cds_pkg::NUM_W;
   localparam int SUM_W  = NUM_W + 1;
   localparam int YEAR_W = cds_pkg::YEAR_W;

   // day number of 31 December LAST_YEAR
   localparam int PB = BASE_YEAR - 1;
   localparam int LAST_NUM = (365 * LAST_YEAR + LAST_YEAR / 4 - LAST_YEAR / 100 +
                              LAST_YEAR / 400) -
                             (365 * PB + PB / 4 - PB / 100 + PB / 400) - 1;
   localparam logic [NUM_W-1:0] LAST_NUM_V = NUM_W'(LAST_NUM);

   // weekday of 1 January BASE_YEAR
   localparam int START_WD = (1 + 5 * (PB % 4) + 4 * (PB % 100) + 6 * (PB % 400)) % 7;

   localparam logic [YEAR_W-1:0] BASE_Y = YEAR_W'(BASE_YEAR);
   localparam logic [YEAR_W-1:0] LAST_Y = YEAR_W'(LAST_YEAR);

   // committed date
   logic [3:0]          cur_month_ff, cur_month_in;
   logic [4:0]          cur_day_ff, cur_day_in;
   logic [YEAR_W-1:0]   cur_year_ff, cur_year_in;
   logic [NUM_W-1:0]    cur_num_ff, cur_num_in;
   logic [2:0]          cur_wd_ff, cur_wd_in;
   logic                busy_ff, busy_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_err_ff, rsp_err_in;

   logic                      accept, go, refuse, fwd_over, back_under, load_ok;
   logic [cds_pkg::STEP_W-1:0] cnt_sat;
   logic [SUM_W-1:0]          fwd_sum;
   logic [NUM_W-1:0]          back_diff;
   logic [YEAR_W-1:0]         ny;
   cds_pkg::job_type          job;
   cds_pkg::res_type          res;

   assign accept = start && !busy_ff;

   // saturate the count, then form the target day number
   assign cnt_sat = ({{(cds_pkg::STEP_LIM_W - cds_pkg::STEP_W){1'b0}}, req_step_count} >
                     cds_pkg::STEP_LIM_W'(MAX_STEP)) ?
                    cds_pkg::STEP_W'(MAX_STEP) : req_step_count;
   assign fwd_sum    = {1'b0, cur_num_ff} + SUM_W'(cnt_sat);
   assign fwd_over   = fwd_sum > SUM_W'(LAST_NUM_V);
   assign back_under = NUM_W'(cnt_sat) > cur_num_ff;
   assign back_diff  = cur_num_ff - NUM_W'(cnt_sat);

   // range checks on a load; the day against its month is checked by the walker
   assign ny      = YEAR_W'(req_new_year);
   assign load_ok = (req_new_month >= 4'd1) && (req_new_month <= 4'(cds_pkg::MONTHS)) &&
                    (req_new_day != 5'd0) && (ny >= BASE_Y) && (ny <= LAST_Y);

   always_comb begin
      job       = '0;
      job.month = req_new_month;
      job.day   = req_new_day;
      job.year  = ny;
      go        = 1'b0;
      case (cds_pkg::op_type'(req_operation))
         cds_pkg::OP_FWD: begin
            go        = 1'b1;
            job.tgt   = fwd_over ? LAST_NUM_V : fwd_sum[NUM_W-1:0];
            job.error = fwd_over;
         end
         cds_pkg::OP_BACK: begin
            go        = 1'b1;
            job.tgt   = back_under ? '0 : back_diff;
            job.error = back_under;
         end
         cds_pkg::OP_LOAD: begin
            go       = load_ok;
            job.load = 1'b1;
         end
         default: begin
            go = 1'b0;
         end
      endcase
   end

   assign refuse = accept && !go;

   cds_walker #(
      .BASE_YEAR (BASE_YEAR),
      .LAST_YEAR (LAST_YEAR),
      .START_WD  (START_WD)
   ) u_walker (
      .clock     (clock),
      .reset     (reset),
      .job_start (accept && go),
      .job       (job),
      .res       (res)
   );

   always_comb begin
      cur_month_in = cur_month_ff;
      cur_day_in   = cur_day_ff;
      cur_year_in  = cur_year_ff;
      cur_num_in   = cur_num_ff;
      cur_wd_in    = cur_wd_ff;
      busy_in      = busy_ff;
      rsp_valid_in = res.valid || refuse;
      rsp_err_in   = rsp_err_ff;
      if (accept && go) begin
         busy_in = 1'b1;
      end
      if (res.valid) begin
         busy_in    = 1'b0;
         rsp_err_in = res.error;
         if (res.commit) begin
            cur_month_in = res.month;
            cur_day_in   = res.day;
            cur_year_in  = res.year;
            cur_num_in   = res.num;
            cur_wd_in    = res.wd;
         end
      end else if (refuse) begin
         rsp_err_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_month_ff <= 4'd1;
         cur_day_ff   <= 5'd1;
         cur_year_ff  <= BASE_Y;
         cur_num_ff   <= '0;
         cur_wd_ff    <= 3'(START_WD);
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_err_ff   <= 1'b0;
      end else begin
         cur_month_ff <= cur_month_in;
         cur_day_ff   <= cur_day_in;
         cur_year_ff  <= cur_year_in;
         cur_num_ff   <= cur_num_in;
         cur_wd_ff    <= cur_wd_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_err_ff   <= rsp_err_in;
      end
   end

   // the date ports show the committed date; rsp_valid marks each result word
   assign busy           = busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_month_out  = cur_month_ff;
   assign rsp_day_out    = cur_day_ff;
   assign rsp_year_out   = cur_year_ff[cds_pkg::OUT_YEAR_W-1:0];
   assign rsp_day_number = cur_num_ff[cds_pkg::OUT_NUM_W-1:0];
   assign rsp_weekday    = cur_wd_ff;
   assign rsp_error_flag = rsp_err_ff;

endmodule

// ===== hw/rtl/cds_checker.sv =====
module cds_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic [1:0]                     req_operation,
   input logic                           rsp_valid,
   input logic [3:0]                     rsp_month_out,
   input logic [4:0]                     rsp_day_out,
   input logic [cds_pkg::OUT_NUM_W-1:0]  rsp_day_number,
   input logic [2:0]                     rsp_weekday,
   input logic                           rsp_error_flag
);

   // end of a walk always gives its result word
   a_busy_ends_in_word: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result word");

   // unused operation code is refused on the next cycle
   a_bad_op_refused: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_operation == cds_pkg::OP_NONE)) |=>
      (rsp_valid && rsp_error_flag))
      else $error("unused operation not refused");

   // the date only moves with a result word
   a_date_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && !$past(reset)) |->
      ($stable(rsp_day_number) && $stable(rsp_weekday) && $stable(rsp_month_out) &&
       $stable(rsp_day_out)))
      else $error("date changed without a result word");

   a_word_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_month_out >= 4'd1) && (rsp_month_out <= 4'd12) &&
                     (rsp_day_out != 5'd0) && (rsp_weekday <= 3'd6)))
      else $error("result word out of range");

endmodule

bind calendar_date_stepper_core cds_checker u_cds_checker (.*);
